/* src/mrba_pkg.sv */
`timescale 1ns / 1ps

package mrba_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_ZERO_SIZE = 3'd1;
    localparam logic [2:0] STAT_NO_SPACE  = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_NOT_LAST  = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  entry_index;
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic [31:0] alloc_size;
        logic [31:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
    } t_out_item;

    // operation travelling down the row of cells
    typedef struct packed {
        logic        valid;
        logic [1:0]  cmd;
        logic [3:0]  entry_index;
        logic [31:0] opa;    // start, size or free address
        logic [31:0] opb;    // end of a loaded region
        logic        found;
        logic        exact;
        logic [31:0] addr;
    } t_token;

endpackage

/* src/multi_region_bump_allocator.sv */
`timescale 1ns / 1ps

// Bump allocator over a table of up to MAX_REGIONS regions, one region per cell in a row of
// cells. Load, allocate and free transactions that reach the table travel down the row one
// cell per clock, and their result is taken from the output of the last cell; allocates
// of size zero or while exhausted, frees of an address that is not the last allocation, and
// unused commands answer without entering the row. One transaction is in the block at a time and the next
// is accepted once the result has been taken. Region entries hold no reset value and must be
// loaded before they are searched. block_count is written only while no transaction is open.
module multi_region_bump_allocator
    import mrba_pkg::*;
#(
    parameter int MAX_REGIONS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_BUSY, S_DONE} t_state;

    t_state        r_state, n_state;
    logic [4:0]    r_block_count, n_block_count;
    logic [IW-1:0] r_current, n_current;
    logic          r_exhausted, n_exhausted;
    logic [31:0]   r_last, n_last;
    t_token        r_launch, n_launch;
    t_out_item     r_out, n_out;
    logic [4:0]    w_count;
    logic          w_accept;
    t_token        w_tok [0:MAX_REGIONS];
    logic [IW-1:0] w_hit [0:MAX_REGIONS];
    t_token        w_exit;

    assign w_count  = (int'(r_block_count) > MAX_REGIONS) ? 5'(MAX_REGIONS) : r_block_count;
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_tok[0] = r_launch;
    assign w_hit[0] = '0;
    assign w_exit   = w_tok[MAX_REGIONS];

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        mrba_cell #(
            .MAX_REGIONS (MAX_REGIONS),
            .CELL_IDX    (g),
            .IW          (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (w_count),
            .i_cur   (r_current),
            .i_tok   (w_tok[g]),
            .i_hit   (w_hit[g]),
            .o_tok   (w_tok[g+1]),
            .o_hit   (w_hit[g+1])
        );
    end

    always_comb begin
        n_state        = r_state;
        n_block_count  = r_block_count;
        n_current      = r_current;
        n_exhausted    = r_exhausted;
        n_last         = r_last;
        n_out          = r_out;
        n_launch       = '0;
        n_launch.cmd   = i_in_data.command;
        n_launch.entry_index = i_in_data.entry_index;
        n_launch.opb   = i_in_data.region_end;
        case (i_in_data.command)
            CMD_ALLOC: n_launch.opa = i_in_data.alloc_size;
            CMD_FREE:  n_launch.opa = i_in_data.free_address;
            default:   n_launch.opa = i_in_data.region_start;
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            n_block_count = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out.result_address = 32'd0;
                    n_out.status         = STAT_OK;
                    n_state              = S_DONE;
                    case (i_in_data.command)
                        CMD_LOAD: begin
                            n_launch.valid = 1'b1;
                            n_state        = S_BUSY;
                        end
                        CMD_ALLOC: begin
                            if (i_in_data.alloc_size == 32'd0) begin
                                n_out.status = STAT_ZERO_SIZE;
                            end else if (r_exhausted) begin
                                n_out.status = STAT_NO_SPACE;
                            end else begin
                                n_launch.valid = 1'b1;
                                n_state        = S_BUSY;
                            end
                        end
                        CMD_FREE: begin
                            if (i_in_data.free_address != r_last) begin
                                n_out.status = STAT_NOT_LAST;
                            end else begin
                                n_launch.valid = 1'b1;
                                n_state        = S_BUSY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUSY: begin
                if (w_exit.valid) begin
                    n_state = S_DONE;
                    case (w_exit.cmd)
                        CMD_ALLOC: begin
                            if (w_exit.found) begin
                                n_out.result_address = w_exit.addr;
                                n_out.status         = STAT_OK;
                                n_last               = w_exit.addr;
                                if (w_exit.exact) begin
                                    if (int'(w_hit[MAX_REGIONS]) + 1 < int'(w_count)) begin
                                        n_current = w_hit[MAX_REGIONS] + IW'(1);
                                    end else begin
                                        n_exhausted = 1'b1;
                                    end
                                end
                            end else begin
                                n_out.status = STAT_NO_SPACE;
                            end
                        end
                        CMD_FREE: begin
                            if (w_exit.found) begin
                                n_current   = w_hit[MAX_REGIONS];
                                n_exhausted = 1'b0;
                                n_out.status = STAT_OK;
                            end else begin
                                n_out.status = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_out.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_block_count  <= 5'd1;
            r_current      <= '0;
            r_exhausted    <= 1'b0;
            r_last         <= 32'd0;
            r_launch.valid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_block_count <= n_block_count;
            r_current     <= n_current;
            r_exhausted   <= n_exhausted;
            r_last        <= n_last;
            r_launch      <= n_launch;
        end
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data  = r_out;
    assign o_cfg_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_exit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> (r_state == S_BUSY))
        else $error("transaction left the cell row outside busy state");

    a_no_launch_in_flight_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_launch.valid && !w_exit.valid))
        else $error("operation in the cell row while result is pending");

    a_free_clears_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit.valid && (w_exit.cmd == CMD_FREE) && w_exit.found) |=> !r_exhausted)
        else $error("successful free left allocator exhausted");

    a_launch_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.valid |-> $past(w_accept))
        else $error("operation launched without an accepted transaction");
`endif

endmodule

/* src/mrba_cell.sv */
`timescale 1ns / 1ps

module mrba_cell
    import mrba_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int CELL_IDX    = 0,
    parameter int IW          = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [4:0]    i_count,
    input  logic [IW-1:0] i_cur,
    input  t_token        i_tok,
    input  logic [IW-1:0] i_hit,
    output t_token        o_tok,
    output logic [IW-1:0] o_hit
);

    logic [31:0]   r_start, r_end, r_ptr;
    logic [31:0]   n_start, n_end, n_ptr;
    t_token        r_tok, n_tok;
    logic [IW-1:0] r_hit, n_hit;
    logic [31:0]   w_room;
    logic          w_live;

    always_comb begin
        w_room  = (r_end > r_ptr) ? (r_end - r_ptr) : 32'd0;
        w_live  = (CELL_IDX < int'(i_count)) && (CELL_IDX < MAX_REGIONS);
        n_tok   = i_tok;
        n_hit   = i_hit;
        n_start = r_start;
        n_end   = r_end;
        n_ptr   = r_ptr;
        if (i_tok.valid) begin
            case (i_tok.cmd)
                CMD_LOAD: begin
                    if (int'(i_tok.entry_index) == CELL_IDX) begin
                        n_start = i_tok.opa;
                        n_end   = i_tok.opb;
                        n_ptr   = i_tok.opa;
                    end
                end
                CMD_ALLOC: begin
                    if (!i_tok.found && w_live && (int'(i_cur) <= CELL_IDX)
                        && (i_tok.opa <= w_room)) begin
                        n_tok.found = 1'b1;
                        n_tok.exact = (i_tok.opa == w_room);
                        n_tok.addr  = r_ptr;
                        n_ptr       = r_ptr + i_tok.opa;
                        n_hit       = IW'(CELL_IDX);
                    end
                end
                CMD_FREE: begin
                    if (w_live) begin
                        if (i_tok.found) begin
                            n_ptr = r_start;
                        end else if ((i_tok.opa >= r_start) && (i_tok.opa < r_end)) begin
                            n_tok.found = 1'b1;
                            n_ptr       = i_tok.opa;
                            n_hit       = IW'(CELL_IDX);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        r_ptr   <= n_ptr;
        r_hit   <= n_hit;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = r_hit;

endmodule

/* test/multi_region_bump_allocator_tb.sv */
`timescale 1ns / 1ps

module multi_region_bump_allocator_tb;
    import mrba_pkg::*;

    localparam int REGION_SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 61;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class allocator_scoreboard;
        bit [31:0] starts[REGION_SLOTS];
        bit [31:0] ends[REGION_SLOTS];
        bit [31:0] ptrs[REGION_SLOTS];
        bit [4:0] cur;
        bit exhausted;
        bit [31:0] last_addr;
        bit [4:0] block_count;
        t_out_item expected_replies[$];
        int fail_count;

        function new();
            cur = '0;
            exhausted = 1'b0;
            last_addr = '0;
            block_count = 5'd1;
            fail_count = 0;
        endfunction

        function void predict_command(t_in_item it);
            t_out_item r;
            int n;
            int i;
            int j;
            bit done;
            bit [31:0] room;
            r.result_address = '0;
            r.status = STAT_OK;
            n = (int'(block_count) > REGION_SLOTS) ? REGION_SLOTS : int'(block_count);
            done = 1'b0;
            case (it.command)
                CMD_LOAD: begin
                    if (int'(it.entry_index) < REGION_SLOTS) begin
                        starts[it.entry_index] = it.region_start;
                        ends[it.entry_index] = it.region_end;
                        ptrs[it.entry_index] = it.region_start;
                    end
                end
                CMD_ALLOC: begin
                    if (it.alloc_size == 0) begin
                        r.status = STAT_ZERO_SIZE;
                    end else if (exhausted) begin
                        r.status = STAT_NO_SPACE;
                    end else begin
                        r.status = STAT_NO_SPACE;
                        for (i = int'(cur); i < n && !done; i++) begin
                            room = (ends[i] > ptrs[i]) ? ends[i] - ptrs[i] : '0;
                            if (it.alloc_size <= room) begin
                                r.result_address = ptrs[i];
                                r.status = STAT_OK;
                                ptrs[i] = ptrs[i] + it.alloc_size;
                                if (it.alloc_size == room) begin
                                    if (i + 1 < n) cur = 5'(i + 1);
                                    else exhausted = 1'b1;
                                end
                                last_addr = r.result_address;
                                done = 1'b1;
                            end
                        end
                    end
                end
                CMD_FREE: begin
                    if (it.free_address != last_addr) begin
                        r.status = STAT_NOT_LAST;
                    end else begin
                        r.status = STAT_NOT_FOUND;
                        for (i = 0; i < n && !done; i++) begin
                            if (it.free_address >= starts[i] && it.free_address < ends[i]) begin
                                ptrs[i] = it.free_address;
                                cur = 5'(i);
                                exhausted = 1'b0;
                                for (j = i + 1; j < n; j++) ptrs[j] = starts[j];
                                r.status = STAT_OK;
                                done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            expected_replies.push_back(r);
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            fail_count++;
            if (fail_count <= 100)
                $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
        endtask

        task check_reply(t_out_item got);
            t_out_item want;
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected transaction", got.result_address, '0);
            end else begin
                want = expected_replies.pop_front();
                if (got.result_address !== want.result_address)
                    report_mismatch("result_address", got.result_address, want.result_address);
                if (got.status !== want.status)
                    report_mismatch("status", {29'd0, got.status}, {29'd0, want.status});
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_item in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [4:0] cfg_data = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out_item o_out_data;
    logic o_cfg_ready;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int block_counts[9] = '{16, 3, 0, 31, 1, 8, 16, 5, 2};

    allocator_scoreboard sb = new();

    multi_region_bump_allocator #(
        .MAX_REGIONS(REGION_SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) sb.check_reply(o_out_data);
    end

    function automatic t_in_item build_item(logic [1:0] cmd, logic [3:0] idx, logic [31:0] first,
                                            logic [31:0] past, logic [31:0] size,
                                            logic [31:0] addr);
        t_in_item it;
        it.command = cmd;
        it.entry_index = idx;
        it.region_start = first;
        it.region_end = past;
        it.alloc_size = size;
        it.free_address = addr;
        return it;
    endfunction

    function automatic t_in_item random_command();
        t_in_item it;
        int pick;
        int k;
        bit [31:0] room;
        it.command = CMD_ALLOC;
        it.entry_index = 4'($urandom);
        it.region_start = $urandom;
        it.region_end = $urandom;
        it.alloc_size = $urandom;
        it.free_address = $urandom;
        pick = $urandom_range(99);
        k = $urandom_range(19);
        if (pick < 8) begin
            it.command = CMD_LOAD;
            if (k != 0) it.region_end = it.region_start + $urandom_range(8, 200);
        end else if (pick < 55) begin
            room = '0;
            if (int'(sb.cur) < REGION_SLOTS && sb.ends[sb.cur] > sb.ptrs[sb.cur])
                room = sb.ends[sb.cur] - sb.ptrs[sb.cur];
            if (k == 0) it.alloc_size = '0;
            else if (k < 6 && room != 0) it.alloc_size = room;
            else if (k != 1) it.alloc_size = $urandom_range(1, 48);
        end else if (pick < 95) begin
            it.command = CMD_FREE;
            if (k < 14) it.free_address = sb.last_addr;
            else if (k < 18) it.free_address = sb.last_addr + $urandom_range(1, 8);
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.predict_command(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_block_count(logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.block_count = value;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] first;
        logic [31:0] past;
        int p;
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 11;
        recv_stall_pct = 47;
        write_block_count(5'd16);

        // full table first so no search ever reads an empty entry
        for (k = 0; k < REGION_SLOTS; k++) begin
            first = (k << 12) | 32'h100;
            past = first + 32'h40;
            if (k == 0) begin
                first = 32'h0;
                past = 32'h20;
            end else if (k == 14) begin
                first = 32'h8000_0000;
                past = 32'h7FFF_FFF0;
            end else if (k == 15) begin
                first = 32'hFFFF_FF00;
                past = 32'hFFFF_FFFF;
            end
            send_item(build_item(CMD_LOAD, 4'(k), first, past, '0, '0));
        end
        send_item(build_item(CMD_ALLOC, '0, '0, '0, 32'h0, '0));
        send_item(build_item(CMD_ALLOC, '0, '0, '0, 32'h20, '0));
        send_item(build_item(CMD_ALLOC, '0, '0, '0, 32'hFFFF_FFFF, '0));
        send_item(build_item(CMD_FREE, '0, '0, '0, '0, 32'h1234));
        send_item(build_item(CMD_ALLOC, '0, '0, '0, 32'h10, '0));
        send_item(build_item(CMD_FREE, '0, '0, '0, '0, 32'h1100));
        send_item(build_item(CMD_UNUSED, '1, '1, '1, '1, '1));
        send_item(build_item(CMD_LOAD, 4'd1, 32'h5000_0000, 32'h5000_0100, '0, '0));
        send_item(build_item(CMD_FREE, '0, '0, '0, '0, 32'h1100));

        for (p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 11;
                    recv_stall_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_stall_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            wait_drained();
            write_block_count(5'(block_counts[p]));
            for (k = 0; k < PHASE_ITEMS; k++) send_item(random_command());
        end

        wait_drained();
        repeat (REGION_SLOTS + 8) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/mrba_pkg.sv
src/mrba_cell.sv
src/multi_region_bump_allocator.sv
test/multi_region_bump_allocator_tb.sv
